// ===== rtl/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack machine executor package
// Shared constants, opcode and kind codes, state type and the structs that
// pass between the sequencer and the divider.
// ----------------------------------------------------------------------------
package smx_pkg;

    // Data memory geometry; the depth is a power of two, so addresses wrap
    // by keeping the low bits.
    localparam int MEM_DEPTH      = 1024;
    localparam int ADDR_BITS      = $clog2(MEM_DEPTH);
    localparam int DISPLAY_LEVELS = 16;
    localparam int LEVEL_BITS     = $clog2(DISPLAY_LEVELS);
    localparam int MAX_STRING     = 63;
    localparam int STR_BITS       = 6;
    localparam int WORD_BITS      = 32;
    localparam int ARG_BITS       = 32;
    localparam int PC_BITS        = 10;
    localparam int OP_BITS        = 6;
    localparam int CNT_BITS       = $clog2(WORD_BITS + 1);

    // Opcodes.
    typedef enum logic [OP_BITS-1:0] {
        OP_ADD    = 6'd0,
        OP_SUB    = 6'd1,
        OP_MULT   = 6'd2,
        OP_DIV    = 6'd3,
        OP_MOD    = 6'd4,
        OP_AND    = 6'd5,
        OP_OR     = 6'd6,
        OP_NEG    = 6'd7,
        OP_NOT    = 6'd8,
        OP_EQ     = 6'd9,
        OP_NE     = 6'd10,
        OP_LT     = 6'd11,
        OP_GT     = 6'd12,
        OP_LE     = 6'd13,
        OP_GE     = 6'd14,
        OP_IN     = 6'd15,
        OP_OUT    = 6'd16,
        OP_NOP    = 6'd17,
        OP_LDC    = 6'd18,
        OP_LDA    = 6'd19,
        OP_LDV    = 6'd20,
        OP_LDI    = 6'd21,
        OP_ST     = 6'd22,
        OP_STI    = 6'd23,
        OP_JMP    = 6'd24,
        OP_JMPF   = 6'd25,
        OP_JMPT   = 6'd26,
        OP_INIT   = 6'd27,
        OP_HALT   = 6'd28,
        OP_ALLOC  = 6'd29,
        OP_CALL   = 6'd30,
        OP_PROC   = 6'd31,
        OP_RET    = 6'd32,
        OP_ENTER  = 6'd33,
        OP_EXIT   = 6'd34,
        OP_DUP    = 6'd35,
        OP_POP    = 6'd36,
        OP_STL    = 6'd37,
        OP_IND    = 6'd38,
        OP_INCH   = 6'd39,
        OP_OUTCH  = 6'd40,
        OP_OUTSTR = 6'd41
    } op_t;

    // What a result word carries.
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_NUM  = 2'd1,
        KIND_CHAR = 2'd2
    } kind_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_TOP,
        S_NXT,
        S_MC,
        S_MD,
        S_DIV,
        S_EXEC,
        S_SRD,
        S_SEM
    } state_t;

    // Divider request and response.
    typedef struct packed {
        logic                 start;
        logic [WORD_BITS-1:0] dividend;
        logic [WORD_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [WORD_BITS-1:0] quot;
        logic [WORD_BITS-1:0] rem;
    } div_rsp_t;

endpackage

// ===== rtl/smx_ram.sv =====
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; read data is registered and holds its
// value while no read is requested.
// ----------------------------------------------------------------------------
module smx_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/smx_div.sv =====
// ----------------------------------------------------------------------------
// Signed word divider
// Restoring division of the magnitudes, one quotient bit per cycle. The
// quotient and remainder magnitudes are held until the next start.
// ----------------------------------------------------------------------------
module smx_div (
    input  logic              clk,
    input  logic              rst_n,
    input  smx_pkg::div_req_t req,
    output smx_pkg::div_rsp_t rsp
);

    import smx_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [WORD_BITS-1:0] quo_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] dsr_reg;
    logic [WORD_BITS:0]   shifted;
    logic [WORD_BITS:0]   diff;

    // One trial subtraction per cycle.
    assign shifted = {rem_reg, quo_reg[WORD_BITS-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(WORD_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: operands enter as magnitudes.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend[WORD_BITS-1] ? -req.dividend : req.dividend;
            dsr_reg <= req.divisor[WORD_BITS-1] ? -req.divisor : req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!diff[WORD_BITS])
            begin
                rem_reg <= diff[WORD_BITS-1:0];
                quo_reg <= {quo_reg[WORD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[WORD_BITS-1:0];
                quo_reg <= {quo_reg[WORD_BITS-2:0], 1'b0};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== rtl/stack_machine_executor.sv =====
// ----------------------------------------------------------------------------
// Stack machine executor
// Executes one stack-machine instruction per input word against a data
// memory, stack pointer, display of frame bases and program counter.
// ----------------------------------------------------------------------------
// After reset the block clears all 1024 words of the data memory and takes no
// words until that is done. The data memory is a single synchronous RAM
// with a registered read port, and unless halted each instruction reads it
// in turn: the top of stack, the word below, and for LDV, LDI, STI and IND
// one or two further words, then most write one result back. DIV and MOD
// with a non-zero divisor wait for the one-bit-per-cycle divider, and OUTSTR
// reads one memory word and gives one output word per character. Each
// instruction gives at least one result word; a registered output stage lets
// the next instruction start while the last result waits to be taken.
module stack_machine_executor (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[5:0], arg_one[37:6], arg_two[69:38], in_value[101:70], zero pad
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_pc[9:0], out_value[41:10], halted[42], div_error[43], zero pad
    output logic [47:0]  m_tdata,
    // out_kind[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    import smx_pkg::*;

    state_t state_reg, state_next;

    // Instruction registers.
    op_t                  op_reg;
    logic [ARG_BITS-1:0]  a1_reg;
    logic [ARG_BITS-1:0]  a2_reg;
    logic [ARG_BITS-1:0]  inv_reg;

    // Operands read from memory.
    logic [WORD_BITS-1:0] top_reg;
    logic [WORD_BITS-1:0] nxt_reg;
    logic [WORD_BITS-1:0] mc_reg;
    logic [WORD_BITS-1:0] md_reg;

    // Architectural state.
    logic [ADDR_BITS-1:0] sp_reg;
    logic [PC_BITS-1:0]   pc_reg;
    logic                 halt_reg;
    logic [WORD_BITS-1:0] fb_reg [DISPLAY_LEVELS];
    logic [ADDR_BITS-1:0] clr_reg;
    logic [ADDR_BITS-1:0] str_sp_reg;
    logic [STR_BITS-1:0]  str_cnt_reg;

    // Output stage.
    logic                 out_valid_reg;
    logic [PC_BITS-1:0]   out_pc_reg;
    kind_t                out_kind_reg;
    logic [31:0]          out_value_reg;
    logic                 out_halt_reg;
    logic                 out_derr_reg;
    logic                 out_last_reg;

    // Memory and divider connections.
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [ADDR_BITS-1:0] ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    // Derived values.
    logic                 accept;
    logic                 out_free;
    logic [ADDR_BITS-1:0] below;
    logic [ADDR_BITS-1:0] up;
    logic [LEVEL_BITS-1:0] lv;
    logic [WORD_BITS-1:0] fb_sel;
    logic [WORD_BITS-1:0] ea_word;
    logic [ADDR_BITS-1:0] ea;
    logic                 need_c;
    logic                 is_div;
    logic [STR_BITS-1:0]  str_n;
    logic [WORD_BITS-1:0] arg2_word;

    // Execute results.
    logic                 ex_we;
    logic [ADDR_BITS-1:0] ex_waddr;
    logic [WORD_BITS-1:0] ex_wdata;
    logic [ADDR_BITS-1:0] sp_next;
    logic [PC_BITS-1:0]   pc_next;
    logic                 halt_next;
    logic                 fb_we;
    logic [LEVEL_BITS-1:0] fb_idx;
    logic [WORD_BITS-1:0] fb_wdata;
    kind_t                ex_kind;
    logic [31:0]          ex_value;
    logic                 ex_derr;
    logic                 ex_emit;
    logic                 str_emit;

    smx_ram #(
        .DEPTH (MEM_DEPTH),
        .WIDTH (WORD_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    smx_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Handshake and addressing helpers.
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign below     = sp_reg - 1'b1;
    assign up        = sp_reg + 1'b1;
    assign lv        = a1_reg[LEVEL_BITS-1:0];
    assign fb_sel    = fb_reg[lv];
    assign arg2_word = WORD_BITS'($signed(a2_reg));
    assign ea_word   = fb_sel + arg2_word;
    assign ea        = ea_word[ADDR_BITS-1:0];
    assign need_c    = (op_reg == OP_LDV) || (op_reg == OP_LDI) || (op_reg == OP_STI);
    assign is_div    = (op_reg == OP_DIV) || (op_reg == OP_MOD);

    // OUTSTR count: negative gives none, large counts saturate.
    always_comb
    begin
        if (a1_reg[ARG_BITS-1])
        begin
            str_n = '0;
        end
        else if (a1_reg[ARG_BITS-2:0] > (ARG_BITS-1)'(MAX_STRING))
        begin
            str_n = STR_BITS'(MAX_STRING);
        end
        else
        begin
            str_n = a1_reg[STR_BITS-1:0];
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                if (clr_reg == ADDR_BITS'(MEM_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = halt_reg ? S_EXEC : S_TOP;
                end
            end
            S_TOP:
            begin
                state_next = S_NXT;
            end
            S_NXT:
            begin
                if (need_c)
                begin
                    state_next = S_MC;
                end
                else if (op_reg == OP_IND)
                begin
                    state_next = S_MD;
                end
                else if (is_div && (top_reg != '0))
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_MC:
            begin
                state_next = (op_reg == OP_LDI) ? S_MD : S_EXEC;
            end
            S_MD:
            begin
                state_next = S_EXEC;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    if (!halt_reg && (op_reg == OP_OUTSTR) && (str_n != '0))
                    begin
                        state_next = S_SRD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SRD:
            begin
                state_next = S_SEM;
            end
            S_SEM:
            begin
                if (out_free)
                begin
                    state_next = (str_cnt_reg == STR_BITS'(1)) ? S_IDLE : S_SRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory and divider control per state.
    always_comb
    begin
        ram_we           = 1'b0;
        ram_waddr        = ex_waddr;
        ram_wdata        = ex_wdata;
        ram_re           = 1'b0;
        ram_raddr        = sp_reg;
        div_req.start    = 1'b0;
        div_req.dividend = ram_rdata;
        div_req.divisor  = top_reg;
        case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            S_IDLE:
            begin
                ram_re    = accept;
                ram_raddr = sp_reg;
            end
            S_TOP:
            begin
                ram_re    = 1'b1;
                ram_raddr = below;
            end
            S_NXT:
            begin
                if (need_c)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ea;
                end
                else if (op_reg == OP_IND)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = top_reg[ADDR_BITS-1:0];
                end
                else if (is_div && (top_reg != '0))
                begin
                    div_req.start = 1'b1;
                end
            end
            S_MC:
            begin
                if (op_reg == OP_LDI)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ram_rdata[ADDR_BITS-1:0];
                end
            end
            S_EXEC:
            begin
                ram_we = ex_we && out_free && !halt_reg;
            end
            S_SRD:
            begin
                ram_re    = 1'b1;
                ram_raddr = str_sp_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Instruction execution on the gathered operands.
    always_comb
    begin
        ex_we     = 1'b0;
        ex_waddr  = below;
        ex_wdata  = '0;
        sp_next   = sp_reg;
        pc_next   = pc_reg + 1'b1;
        halt_next = halt_reg;
        fb_we     = 1'b0;
        fb_idx    = lv;
        fb_wdata  = top_reg;
        ex_kind   = KIND_NONE;
        ex_value  = '0;
        ex_derr   = 1'b0;
        case (op_reg)
            OP_ADD, OP_SUB, OP_MULT, OP_AND, OP_OR, OP_EQ, OP_NE,
            OP_LT, OP_GT, OP_LE, OP_GE:
            begin
                ex_we   = 1'b1;
                sp_next = below;
                case (op_reg)
                    OP_ADD:  ex_wdata = nxt_reg + top_reg;
                    OP_SUB:  ex_wdata = nxt_reg - top_reg;
                    OP_MULT: ex_wdata = nxt_reg * top_reg;
                    OP_AND:  ex_wdata = WORD_BITS'((nxt_reg != '0) && (top_reg != '0));
                    OP_OR:   ex_wdata = WORD_BITS'((nxt_reg != '0) || (top_reg != '0));
                    OP_EQ:   ex_wdata = WORD_BITS'(nxt_reg == top_reg);
                    OP_NE:   ex_wdata = WORD_BITS'(nxt_reg != top_reg);
                    OP_LT:   ex_wdata = WORD_BITS'($signed(nxt_reg) < $signed(top_reg));
                    OP_GT:   ex_wdata = WORD_BITS'($signed(top_reg) < $signed(nxt_reg));
                    OP_LE:   ex_wdata = WORD_BITS'(!($signed(top_reg) < $signed(nxt_reg)));
                    OP_GE:   ex_wdata = WORD_BITS'(!($signed(nxt_reg) < $signed(top_reg)));
                    default: ex_wdata = '0;
                endcase
            end
            OP_DIV, OP_MOD:
            begin
                ex_we   = 1'b1;
                sp_next = below;
                if (top_reg == '0)
                begin
                    ex_derr  = 1'b1;
                    ex_wdata = '0;
                end
                else if (op_reg == OP_DIV)
                begin
                    ex_wdata = (nxt_reg[WORD_BITS-1] ^ top_reg[WORD_BITS-1]) ?
                               -div_rsp.quot : div_rsp.quot;
                end
                else
                begin
                    ex_wdata = nxt_reg[WORD_BITS-1] ? -div_rsp.rem : div_rsp.rem;
                end
            end
            OP_NEG:
            begin
                ex_we    = 1'b1;
                ex_waddr = sp_reg;
                ex_wdata = -top_reg;
            end
            OP_NOT:
            begin
                ex_we    = 1'b1;
                ex_waddr = sp_reg;
                ex_wdata = WORD_BITS'(top_reg == '0);
            end
            OP_IN, OP_INCH:
            begin
                ex_we    = 1'b1;
                ex_waddr = up;
                ex_wdata = WORD_BITS'($signed(inv_reg));
                sp_next  = up;
            end
            OP_OUT:
            begin
                ex_kind  = KIND_NUM;
                ex_value = 32'(top_reg);
                sp_next  = below;
            end
            OP_LDC:
            begin
                ex_we    = 1'b1;
                ex_waddr = up;
                ex_wdata = WORD_BITS'($signed(a1_reg));
                sp_next  = up;
            end
            OP_LDA:
            begin
                ex_we    = 1'b1;
                ex_waddr = up;
                ex_wdata = ea_word;
                sp_next  = up;
            end
            OP_LDV:
            begin
                ex_we    = 1'b1;
                ex_waddr = up;
                ex_wdata = mc_reg;
                sp_next  = up;
            end
            OP_LDI:
            begin
                ex_we    = 1'b1;
                ex_waddr = up;
                ex_wdata = md_reg;
                sp_next  = up;
            end
            OP_ST:
            begin
                ex_we    = 1'b1;
                ex_waddr = ea;
                ex_wdata = top_reg;
                sp_next  = below;
            end
            OP_STI:
            begin
                ex_we    = 1'b1;
                ex_waddr = mc_reg[ADDR_BITS-1:0];
                ex_wdata = top_reg;
                sp_next  = below;
            end
            OP_JMP:
            begin
                pc_next = a1_reg[PC_BITS-1:0];
            end
            OP_JMPF:
            begin
                if (top_reg == '0)
                begin
                    pc_next = a1_reg[PC_BITS-1:0];
                end
                sp_next = below;
            end
            OP_JMPT:
            begin
                if (top_reg != '0)
                begin
                    pc_next = a1_reg[PC_BITS-1:0];
                end
                sp_next = below;
            end
            OP_INIT:
            begin
                sp_next  = '0;
                fb_we    = 1'b1;
                fb_idx   = '0;
                fb_wdata = '0;
            end
            OP_HALT:
            begin
                halt_next = 1'b1;
                pc_next   = pc_reg;
            end
            OP_ALLOC:
            begin
                sp_next = sp_reg + a1_reg[ADDR_BITS-1:0];
            end
            OP_CALL:
            begin
                ex_we    = 1'b1;
                ex_waddr = up;
                ex_wdata = WORD_BITS'(pc_reg + 1'b1);
                sp_next  = up;
                pc_next  = a1_reg[PC_BITS-1:0];
            end
            OP_PROC, OP_ENTER:
            begin
                ex_we    = 1'b1;
                ex_waddr = up;
                ex_wdata = fb_sel;
                sp_next  = up;
                fb_we    = 1'b1;
                fb_wdata = WORD_BITS'(up);
            end
            OP_RET:
            begin
                fb_we   = 1'b1;
                pc_next = nxt_reg[PC_BITS-1:0];
                sp_next = below - 1'b1;
            end
            OP_EXIT:
            begin
                fb_we   = 1'b1;
                sp_next = below;
            end
            OP_DUP:
            begin
                ex_we    = 1'b1;
                ex_waddr = up;
                ex_wdata = top_reg;
                sp_next  = up;
            end
            OP_POP:
            begin
                sp_next = below;
            end
            OP_STL:
            begin
                ex_we    = 1'b1;
                ex_waddr = nxt_reg[ADDR_BITS-1:0];
                ex_wdata = top_reg;
                sp_next  = below - 1'b1;
            end
            OP_IND:
            begin
                ex_we    = 1'b1;
                ex_waddr = sp_reg;
                ex_wdata = md_reg;
            end
            OP_OUTCH:
            begin
                ex_kind  = KIND_CHAR;
                ex_value = {24'd0, top_reg[7:0]};
                sp_next  = below;
            end
            default:
            begin
                ex_we = 1'b0;
            end
        endcase
    end

    // Emit strobes for the output stage.
    assign ex_emit  = (state_reg == S_EXEC) && out_free &&
                      (halt_reg || (op_reg != OP_OUTSTR) || (str_n == '0));
    assign str_emit = (state_reg == S_SEM) && out_free;

    // Control and architectural registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            sp_reg        <= '0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            str_cnt_reg   <= '0;
            for (int i = 0; i < DISPLAY_LEVELS; i++)
            begin
                fb_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (ex_emit || str_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == S_EXEC) && out_free && !halt_reg)
            begin
                sp_reg   <= sp_next;
                pc_reg   <= pc_next;
                halt_reg <= halt_next;
                if (fb_we)
                begin
                    fb_reg[fb_idx] <= fb_wdata;
                end
                str_cnt_reg <= str_n;
            end
            if (str_emit)
            begin
                str_cnt_reg <= str_cnt_reg - 1'b1;
                if (str_cnt_reg == STR_BITS'(1))
                begin
                    sp_reg <= str_sp_reg - 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(s_tdata[5:0]);
            a1_reg  <= s_tdata[37:6];
            a2_reg  <= s_tdata[69:38];
            inv_reg <= s_tdata[101:70];
        end
        if (state_reg == S_TOP)
        begin
            top_reg <= ram_rdata;
        end
        if (state_reg == S_NXT)
        begin
            nxt_reg <= ram_rdata;
        end
        if (state_reg == S_MC)
        begin
            mc_reg <= ram_rdata;
        end
        if (state_reg == S_MD)
        begin
            md_reg <= ram_rdata;
        end
        if ((state_reg == S_EXEC) && out_free)
        begin
            str_sp_reg <= sp_reg;
        end
        if (str_emit)
        begin
            str_sp_reg <= str_sp_reg - 1'b1;
        end
        if (ex_emit)
        begin
            out_pc_reg    <= halt_reg ? pc_reg : pc_next;
            out_kind_reg  <= halt_reg ? KIND_NONE : ex_kind;
            out_value_reg <= halt_reg ? 32'd0 : ex_value;
            out_halt_reg  <= halt_reg ? 1'b1 : halt_next;
            out_derr_reg  <= halt_reg ? 1'b0 : ex_derr;
            out_last_reg  <= 1'b1;
        end
        else if (str_emit)
        begin
            out_pc_reg    <= pc_reg;
            out_kind_reg  <= KIND_CHAR;
            out_value_reg <= {24'd0, ram_rdata[7:0]};
            out_halt_reg  <= halt_reg;
            out_derr_reg  <= 1'b0;
            out_last_reg  <= (str_cnt_reg == STR_BITS'(1));
        end
    end

    // Output ports.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_derr_reg, out_halt_reg, out_value_reg, out_pc_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // The divider is only started when idle and only finishes while waited on.
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the wait state");

    // The clearing pass writes only zeros.
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> (ram_we && (ram_wdata == '0)))
        else $error("clearing pass wrote non-zero data");

    // One instruction at a time: no word is taken straight after another.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("second word accepted while executing");

endmodule
